>>> sv/zps_pkg.sv
// Shared types, constants and helper functions of the zonal percentile stretch unit.
package zps_pkg;

    localparam int ZONES   = 64;
    localparam int PERIODS = 36;
    localparam int DEPTH   = ZONES * PERIODS;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam int ZONE_W = 6;
    localparam int PER_W  = 6;
    localparam int VAL_W  = 15;
    localparam int BAND_W = 12;
    localparam int CFG_W  = 6;
    localparam int PCT_W  = 7;

    localparam logic [CFG_W-1:0] START_RESET = CFG_W'(0);
    localparam logic [CFG_W-1:0] PC_RESET    = CFG_W'(PERIODS);

    // period remainder pipeline: MOD_STEPS dividend bits per stage
    localparam int MOD_STEPS  = 4;
    localparam int MOD_STAGES = 4;
    localparam int MOD_W      = MOD_STEPS * MOD_STAGES;

    // ratio datapath widths
    localparam int DIF_W  = VAL_W + 1;
    localparam int NUM_W  = 23;
    localparam int MAG_W  = 22;
    localparam int DMAG_W = VAL_W;
    localparam int Q_W    = 7;
    localparam int Q_LO   = 4;

    localparam int PCT_MAX       = 100;
    localparam int BAND_ZERO_MAX = 5;
    localparam int BAND_TEN_MAX  = 10;
    localparam int BAND_TEN      = 10;
    localparam logic signed [NUM_W-1:0] K_SCALE = NUM_W'(PCT_MAX);

    // input tdata layout
    localparam int IN_TDATA_W = 72;
    localparam int ZONE_LSB   = 0;
    localparam int ZVALID_BIT = 6;
    localparam int PERIOD_LSB = 7;
    localparam int LOW_LSB    = 13;
    localparam int HIGH_LSB   = 28;
    localparam int BAND_LSB   = 43;
    localparam int SAMPLE_LSB = 55;

    // output tdata layout
    localparam int OUT_TDATA_W = 8;
    localparam int DEGEN_BIT   = 7;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    typedef enum logic {
        CFG_START_DEKAD  = 1'b0,
        CFG_PERIOD_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                    valid;
        t_cmd                    cmd;
        logic                    zone_valid;
        logic [ZONE_W-1:0]       zone;
        logic [PER_W-1:0]        period;
        logic signed [VAL_W-1:0] low_bound;
        logic signed [VAL_W-1:0] high_bound;
        logic signed [VAL_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic valid;
        logic active;
    } t_ctl;

    // MOD_STEPS restoring remainder steps, most significant dividend bit first
    function automatic logic [PER_W-1:0] mod_steps(input logic [PER_W-1:0]     rem_in,
                                                   input logic [MOD_STEPS-1:0] bits,
                                                   input logic [PER_W-1:0]     divisor);
        logic [PER_W:0]   t;
        logic [PER_W-1:0] r;
        r = rem_in;
        for (int i = MOD_STEPS - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, divisor}) begin
                t = t - {1'b0, divisor};
            end
            r = t[PER_W-1:0];
        end
        return r;
    endfunction

    // clamp the quotient to 100 and apply the low bands
    function automatic logic [PCT_W-1:0] band_pct(input logic [Q_W-1:0] q,
                                                  input logic           sat);
        logic [PCT_W-1:0] c;
        c = (sat || (q > Q_W'(PCT_MAX))) ? PCT_W'(PCT_MAX) : PCT_W'(q);
        if (c <= PCT_W'(BAND_ZERO_MAX)) begin
            c = '0;
        end else if (c <= PCT_W'(BAND_TEN_MAX)) begin
            c = PCT_W'(BAND_TEN);
        end
        return c;
    endfunction

endpackage

>>> sv/zonal_percentile_stretch_unit.sv
// Top level of the zonal percentile stretch unit: period lookup, bound tables, output skid.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready | i_s_tdata fields, i_s_tuser = cmd
//  m       | out | o_m_tvalid/i_m_tready | o_m_tdata = percentage, degenerate
//  cfg     | in  | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// Accepts one transaction per cycle while o_s_tready is high; a sample result passes through
// a 4-stage remainder pipeline for the period, one table read, a 4-stage ratio divider.
// Table writes travel the same pipeline, so reads and writes hit the RAMs in arrival order.
// Synchronous active-low reset clears valid bits and resets configuration; tables are not cleared.
// A two-entry output register plus skid absorbs a stall; o_s_tready drops once the skid fills.
module zonal_percentile_stretch_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // zone, zone_valid, period, low_bound, high_bound, band_index, sample, zero fill
    input  logic [zps_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // cmd
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // percentage, degenerate
    output logic [zps_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input  logic                              i_cfg_we,
    input  zps_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [zps_pkg::CFG_W-1:0]         i_cfg_data
);
    import zps_pkg::*;

    logic [CFG_W-1:0] r_start_dekad;
    logic [CFG_W-1:0] r_period_count;
    logic [PER_W-1:0] w_pc;

    logic  w_adv;
    t_item w_in;
    t_item r_item [MOD_STAGES+1];
    logic [MOD_W-1:0] r_dvd [MOD_STAGES+1];
    logic [PER_W-1:0] r_rem [MOD_STAGES+1];

    logic [ADDR_W-1:0] w_addr;
    logic [PER_W-1:0]  w_col;
    logic              w_ram_en;
    logic              w_ram_we;
    logic [VAL_W-1:0]  w_low_rd;
    logic [VAL_W-1:0]  w_high_rd;

    t_ctl                    r_s5_ctl;
    logic signed [VAL_W-1:0] r_s5_sample;

    t_ctl             w_res_ctl;
    logic [PCT_W-1:0] w_res_pct;
    logic             w_res_degen;

    logic                   r_out_v;
    logic                   r_skid_v;
    logic [OUT_TDATA_W-1:0] r_out;
    logic [OUT_TDATA_W-1:0] r_skid;
    logic                   w_load_out;
    logic                   w_load_skid;
    logic                   w_skid_to_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_dekad  <= START_RESET;
            r_period_count <= PC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_DEKAD:  r_start_dekad  <= i_cfg_data;
                CFG_PERIOD_COUNT: r_period_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_period_count == '0) begin
            w_pc = PER_W'(1);
        end else if (r_period_count > CFG_W'(PERIODS)) begin
            w_pc = PER_W'(PERIODS);
        end else begin
            w_pc = PER_W'(r_period_count);
        end
    end

    // input unpack
    assign w_adv      = !r_skid_v;
    assign o_s_tready = w_adv;

    always_comb begin
        w_in.valid      = i_s_tvalid;
        w_in.cmd        = t_cmd'(i_s_tuser);
        w_in.zone       = i_s_tdata[ZONE_LSB +: ZONE_W];
        w_in.zone_valid = i_s_tdata[ZVALID_BIT];
        w_in.period     = i_s_tdata[PERIOD_LSB +: PER_W];
        w_in.low_bound  = i_s_tdata[LOW_LSB +: VAL_W];
        w_in.high_bound = i_s_tdata[HIGH_LSB +: VAL_W];
        w_in.sample     = i_s_tdata[SAMPLE_LSB +: VAL_W];
    end

    // period = (band_index + start_dekad) mod clamped period_count, MOD_STEPS bits per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MOD_STAGES; k++) begin
                r_item[k].valid <= 1'b0;
            end
        end else if (w_adv) begin
            r_item[0] <= w_in;
            for (int k = 1; k <= MOD_STAGES; k++) begin
                r_item[k] <= r_item[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dvd[0] <= MOD_W'(i_s_tdata[BAND_LSB +: BAND_W]) + MOD_W'(r_start_dekad);
            r_rem[0] <= '0;
            for (int k = 1; k <= MOD_STAGES; k++) begin
                r_dvd[k] <= r_dvd[k-1] << MOD_STEPS;
                r_rem[k] <= mod_steps(r_rem[k-1], r_dvd[k-1][MOD_W-1 -: MOD_STEPS], w_pc);
            end
        end
    end

    // table access: writes use their period column, samples the computed one
    always_comb begin
        w_col    = (r_item[MOD_STAGES].cmd == CMD_WRITE) ? r_item[MOD_STAGES].period
                                                         : r_rem[MOD_STAGES];
        w_addr   = ADDR_W'(r_item[MOD_STAGES].zone) * ADDR_W'(PERIODS) + ADDR_W'(w_col);
        w_ram_we = (r_item[MOD_STAGES].cmd == CMD_WRITE);
        // drop writes to a column past the table
        w_ram_en = w_adv && r_item[MOD_STAGES].valid &&
                   (!w_ram_we || (r_item[MOD_STAGES].period < PER_W'(PERIODS)));
    end

    zps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_low_store (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_addr),
        .i_wdata (r_item[MOD_STAGES].low_bound),
        .o_rdata (w_low_rd)
    );

    zps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_high_store (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_addr),
        .i_wdata (r_item[MOD_STAGES].high_bound),
        .o_rdata (w_high_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_ctl <= '0;
        end else if (w_adv) begin
            r_s5_ctl.valid  <= r_item[MOD_STAGES].valid &&
                               (r_item[MOD_STAGES].cmd == CMD_SAMPLE);
            r_s5_ctl.active <= r_item[MOD_STAGES].zone_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_sample <= r_item[MOD_STAGES].sample;
        end
    end

    zps_ratio u_ratio (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_ctl        (r_s5_ctl),
        .i_high       (signed'(w_high_rd)),
        .i_low        (signed'(w_low_rd)),
        .i_sample     (r_s5_sample),
        .o_ctl        (w_res_ctl),
        .o_percentage (w_res_pct),
        .o_degenerate (w_res_degen)
    );

    // output register and skid
    always_comb begin
        w_skid_to_out = r_skid_v && i_m_tready;
        w_load_out    = !r_skid_v && w_res_ctl.valid && (!r_out_v || i_m_tready);
        w_load_skid   = !r_skid_v && w_res_ctl.valid && r_out_v && !i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_skid_to_out) begin
                r_skid_v <= 1'b0;
            end else if (w_load_skid) begin
                r_skid_v <= 1'b1;
            end
            if (w_load_out) begin
                r_out_v <= 1'b1;
            end else if (!r_skid_v && i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_skid_to_out) begin
            r_out <= r_skid;
        end else if (w_load_out) begin
            r_out <= {w_res_degen, w_res_pct};
        end
        if (w_load_skid) begin
            r_skid <= {w_res_degen, w_res_pct};
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output entry");

    a_stall_holds_table_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_item[MOD_STAGES]) && $stable(r_s5_ctl))
        else $error("pipeline moved during a stall");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[DEGEN_BIT] |-> (o_m_tdata[PCT_W-1:0] == '0))
        else $error("degenerate result with nonzero percentage");

    a_banded_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[PCT_W-1:0] <= PCT_W'(PCT_MAX)) &&
                       ((o_m_tdata[PCT_W-1:0] == '0) ||
                        (o_m_tdata[PCT_W-1:0] >= PCT_W'(BAND_TEN))))
        else $error("percentage outside the banded range");

endmodule

>>> sv/zps_ram.sv
// Generic single-port RAM with registered read data.
module zps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/zps_ratio.sv
// Pipelined stretch ratio: 100*(high-sample)/(high-low), clamped and banded.
module zps_ratio (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  zps_pkg::t_ctl                    i_ctl,
    input  logic signed [zps_pkg::VAL_W-1:0] i_high,
    input  logic signed [zps_pkg::VAL_W-1:0] i_low,
    input  logic signed [zps_pkg::VAL_W-1:0] i_sample,
    output zps_pkg::t_ctl                    o_ctl,
    output logic [zps_pkg::PCT_W-1:0]        o_percentage,
    output logic                             o_degenerate
);
    import zps_pkg::*;

    // stage 1: differences
    t_ctl                    r1_ctl;
    logic signed [DIF_W-1:0] r1_den;
    logic signed [DIF_W-1:0] r1_dif;

    // stage 2: magnitudes and sign outcome
    t_ctl              r2_ctl;
    logic [MAG_W-1:0]  r2_mag;
    logic [DMAG_W-1:0] r2_dmag;
    logic              r2_pos;
    logic              r2_degen;

    // stages 3 and 4: quotient bits, high part then low part
    t_ctl              r3_ctl;
    logic [MAG_W-1:0]  r3_rem;
    logic [DMAG_W-1:0] r3_dmag;
    logic [Q_W-1:0]    r3_q;
    logic              r3_sat;
    logic              r3_pos;
    logic              r3_degen;

    t_ctl           r4_ctl;
    logic [Q_W-1:0] r4_q;
    logic           r4_sat;
    logic           r4_pos;
    logic           r4_degen;

    logic signed [NUM_W-1:0] n2_num;
    logic [MAG_W-1:0]        n3_rem;
    logic [Q_W-1:0]          n3_q;
    logic                    n3_sat;
    logic [Q_W-1:0]          n4_q;

    always_comb begin
        n2_num = NUM_W'(r1_dif) * K_SCALE;
    end

    always_comb begin
        logic [MAG_W-1:0] r;
        logic [MAG_W-1:0] cand;
        r      = r2_mag;
        n3_q   = '0;
        n3_sat = (r2_mag >= (MAG_W'(r2_dmag) << Q_W));
        for (int k = Q_W - 1; k >= Q_LO; k--) begin
            cand = MAG_W'(r2_dmag) << k;
            if (r >= cand) begin
                r       = r - cand;
                n3_q[k] = 1'b1;
            end
        end
        n3_rem = r;
    end

    always_comb begin
        logic [MAG_W-1:0] r;
        logic [MAG_W-1:0] cand;
        r    = r3_rem;
        n4_q = r3_q;
        for (int k = Q_LO - 1; k >= 0; k--) begin
            cand = MAG_W'(r3_dmag) << k;
            if (r >= cand) begin
                r       = r - cand;
                n4_q[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else if (i_adv) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_den   <= DIF_W'(i_high) - DIF_W'(i_low);
            r1_dif   <= DIF_W'(i_high) - DIF_W'(i_sample);
            r2_mag   <= n2_num[NUM_W-1] ? MAG_W'(-n2_num) : MAG_W'(n2_num);
            r2_dmag  <= r1_den[DIF_W-1] ? DMAG_W'(-r1_den) : DMAG_W'(r1_den);
            // a negative or zero quotient clamps to zero
            r2_pos   <= (r1_dif != '0) && (r1_den != '0) &&
                        (r1_dif[DIF_W-1] == r1_den[DIF_W-1]);
            r2_degen <= (r1_den == '0);
            r3_rem   <= n3_rem;
            r3_dmag  <= r2_dmag;
            r3_q     <= n3_q;
            r3_sat   <= n3_sat;
            r3_pos   <= r2_pos;
            r3_degen <= r2_degen;
            r4_q     <= n4_q;
            r4_sat   <= r3_sat;
            r4_pos   <= r3_pos;
            r4_degen <= r3_degen;
        end
    end

    always_comb begin
        o_ctl        = r4_ctl;
        o_percentage = '0;
        o_degenerate = 1'b0;
        if (r4_ctl.active) begin
            if (r4_degen) begin
                o_degenerate = 1'b1;
            end else if (r4_pos) begin
                o_percentage = band_pct(r4_q, r4_sat);
            end
        end
    end

endmodule

>>> dv/zonal_percentile_stretch_unit_tb.sv
// Testbench for the zonal percentile stretch unit: bound table writes, samples, random handshakes.
module zonal_percentile_stretch_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import zps_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_ITEMS  = 80;
    localparam int VAL_MIN      = -(1 << (VAL_W - 1));
    localparam int VAL_MAX      = (1 << (VAL_W - 1)) - 1;

    class stretch_scoreboard;
        logic signed [VAL_W-1:0] low_tab [DEPTH];
        logic signed [VAL_W-1:0] high_tab[DEPTH];
        logic [CFG_W-1:0]        start_dekad;
        logic [CFG_W-1:0]        period_count;
        logic [OUT_TDATA_W-1:0]  pct_q[$];
        int errors;
        int n_writes;
        int n_samples;
        int n_degen;
        int n_checked;

        function new();
            start_dekad  = START_RESET;
            period_count = PC_RESET;
            errors       = 0;
            n_writes     = 0;
            n_samples    = 0;
            n_degen      = 0;
            n_checked    = 0;
        endfunction

        function int period_of(input logic [BAND_W-1:0] band);
            int pc;
            pc = period_count;
            if (pc == 0) pc = 1;
            if (pc > PERIODS) pc = PERIODS;
            return (int'(band) + int'(start_dekad)) % pc;
        endfunction

        function void note_input(input t_cmd cmd, input logic [IN_TDATA_W-1:0] d);
            logic [ZONE_W-1:0]       zone;
            logic                    zvalid;
            logic [PER_W-1:0]        per;
            logic signed [VAL_W-1:0] lo_f;
            logic signed [VAL_W-1:0] hi_f;
            logic signed [VAL_W-1:0] smp;
            logic [BAND_W-1:0]       band;
            int                      idx;
            int                      den;
            int                      q;
            logic [PCT_W-1:0]        pct;
            logic                    degen;
            zone   = d[ZONE_LSB +: ZONE_W];
            zvalid = d[ZVALID_BIT];
            per    = d[PERIOD_LSB +: PER_W];
            lo_f   = d[LOW_LSB +: VAL_W];
            hi_f   = d[HIGH_LSB +: VAL_W];
            band   = d[BAND_LSB +: BAND_W];
            smp    = d[SAMPLE_LSB +: VAL_W];
            if (cmd == CMD_WRITE) begin
                n_writes++;
                // drop writes outside the table
                if (int'(zone) < ZONES && int'(per) < PERIODS) begin
                    idx = int'(zone) * PERIODS + int'(per);
                    low_tab[idx]  = lo_f;
                    high_tab[idx] = hi_f;
                end
                return;
            end
            n_samples++;
            pct   = '0;
            degen = 1'b0;
            if (zvalid && int'(zone) < ZONES) begin
                idx = int'(zone) * PERIODS + period_of(band);
                den = int'(high_tab[idx]) - int'(low_tab[idx]);
                if (den == 0) begin
                    degen = 1'b1;
                    n_degen++;
                end else begin
                    q = (PCT_MAX * (int'(high_tab[idx]) - int'(smp))) / den;
                    if (q < 0) q = 0;
                    if (q > PCT_MAX) q = PCT_MAX;
                    if (q <= BAND_ZERO_MAX) q = 0;
                    else if (q <= BAND_TEN_MAX) q = BAND_TEN;
                    pct = PCT_W'(q);
                end
            end
            pct_q.push_back({degen, pct});
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] d);
            logic [OUT_TDATA_W-1:0] e;
            if (pct_q.size() == 0) begin
                $display("%0t: result with nothing expected: actual %h", $time, d);
                errors++;
                return;
            end
            e = pct_q.pop_front();
            n_checked++;
            if (d[PCT_W-1:0] !== e[PCT_W-1:0]) begin
                $display("%0t: percentage mismatch: expected %0d actual %0d",
                         $time, e[PCT_W-1:0], d[PCT_W-1:0]);
                errors++;
            end
            if (d[DEGEN_BIT] !== e[DEGEN_BIT]) begin
                $display("%0t: degenerate mismatch: expected %0b actual %0b",
                         $time, e[DEGEN_BIT], d[DEGEN_BIT]);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_we;
    t_cfg_idx               i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;

    stretch_scoreboard sb = new();
    bit filled[DEPTH];
    bit calm = 1'b0;
    int cycle_count = 0;

    zonal_percentile_stretch_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
        end
    end

    // result side: unless calm, drop i_m_tready for a random stall before each transaction
    initial begin
        int stall;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    function automatic logic [IN_TDATA_W-1:0] item_data(
        input logic [ZONE_W-1:0] zone, input logic zvalid, input logic [PER_W-1:0] per,
        input logic signed [VAL_W-1:0] lo, input logic signed [VAL_W-1:0] hi,
        input logic [BAND_W-1:0] band, input logic signed [VAL_W-1:0] smp);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[ZONE_LSB +: ZONE_W]   = zone;
        d[ZVALID_BIT]           = zvalid;
        d[PERIOD_LSB +: PER_W]  = per;
        d[LOW_LSB +: VAL_W]     = lo;
        d[HIGH_LSB +: VAL_W]    = hi;
        d[BAND_LSB +: BAND_W]   = band;
        d[SAMPLE_LSB +: VAL_W]  = smp;
        return d;
    endfunction

    // mostly ordered bounds, with equal, reversed and full-scale pairs mixed in
    task automatic draw_bounds(output logic signed [VAL_W-1:0] lo,
                               output logic signed [VAL_W-1:0] hi);
        int a;
        int b;
        int t;
        int kind;
        kind = $urandom_range(0, 9);
        a = int'($urandom_range(0, 20000)) - 10000;
        b = int'($urandom_range(0, 20000)) - 10000;
        case (kind)
            0: b = a;
            1: begin
                a = int'($urandom_range(0, 32767)) + VAL_MIN;
                b = int'($urandom_range(0, 32767)) + VAL_MIN;
            end
            2: begin
                a = VAL_MIN;
                b = VAL_MAX;
            end
            3: begin
                if (a < b) begin
                    t = a; a = b; b = t;
                end
            end
            default: begin
                if (a > b) begin
                    t = a; a = b; b = t;
                end
            end
        endcase
        if (kind != 3 && $urandom_range(0, 15) == 0) begin
            t = a; a = b; b = t;
        end
        lo = VAL_W'(a);
        hi = VAL_W'(b);
    endtask

    // keep most samples near the bounds so every band is reached
    function automatic logic signed [VAL_W-1:0] draw_sample(input int lo, input int hi);
        int span;
        int s;
        span = (hi > lo) ? hi - lo : lo - hi;
        if (span == 0 || $urandom_range(0, 3) == 0) begin
            return VAL_W'($urandom);
        end
        s = ((hi > lo) ? lo : hi) - span / 8 + int'($urandom_range(0, span + span / 4));
        if (s < VAL_MIN) s = VAL_MIN;
        if (s > VAL_MAX) s = VAL_MAX;
        return VAL_W'(s);
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [IN_TDATA_W-1:0] d);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(cmd, d);
    endtask

    task automatic write_entry(input logic [ZONE_W-1:0] zone, input logic [PER_W-1:0] per,
                               input logic signed [VAL_W-1:0] lo,
                               input logic signed [VAL_W-1:0] hi);
        send_item(CMD_WRITE, item_data(zone, 1'($urandom), per, lo, hi,
                                       BAND_W'($urandom), VAL_W'($urandom)));
        if (int'(per) < PERIODS) filled[int'(zone) * PERIODS + int'(per)] = 1'b1;
    endtask

    // load the entry the sample will read first, so no unwritten entry is ever read
    task automatic sample_at(input logic [ZONE_W-1:0] zone, input logic [BAND_W-1:0] band,
                             input logic signed [VAL_W-1:0] smp);
        int p;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        p = sb.period_of(band);
        if (!filled[int'(zone) * PERIODS + p]) begin
            draw_bounds(lo, hi);
            write_entry(zone, PER_W'(p), lo, hi);
        end
        send_item(CMD_SAMPLE, item_data(zone, 1'b1, PER_W'($urandom), VAL_W'($urandom),
                                        VAL_W'($urandom), band, smp));
    endtask

    task automatic random_item();
        int roll;
        int idx;
        logic [ZONE_W-1:0] zone;
        logic [BAND_W-1:0] band;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        logic [IN_TDATA_W-1:0] d;
        roll = $urandom_range(0, 19);
        zone = ($urandom_range(0, 1) == 0) ? ZONE_W'($urandom_range(0, 3)) : ZONE_W'($urandom);
        if (roll < 4) begin
            draw_bounds(lo, hi);
            write_entry(zone, PER_W'($urandom), lo, hi);
        end else if (roll < 17) begin
            band = BAND_W'($urandom);
            idx  = int'(zone) * PERIODS + sb.period_of(band);
            if (!filled[idx]) begin
                draw_bounds(lo, hi);
                write_entry(zone, PER_W'(sb.period_of(band)), lo, hi);
            end
            sample_at(zone, band, draw_sample(int'(sb.low_tab[idx]), int'(sb.high_tab[idx])));
        end else begin
            d = IN_TDATA_W'({$urandom, $urandom, $urandom});
            d[ZVALID_BIT] = 1'b0;
            d[IN_TDATA_W-1:SAMPLE_LSB + VAL_W] = '0;
            send_item(CMD_SAMPLE, d);
        end
    endtask

    // hold until every result is back and the pipeline has emptied
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pct_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_START_DEKAD) sb.start_dekad = v;
        else sb.period_count = v;
        @(posedge i_clk);
    endtask

    initial begin
        int start_set[NUM_PHASES];
        int pc_set[NUM_PHASES];
        start_set  = '{0, 35, 0, 63, 17, 35, 9};
        pc_set     = '{36, 1, 0, 63, 7, 36, 13};
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= CMD_WRITE;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_START_DEKAD;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // band edges of the stretch with bounds -10000 to 10000
        write_entry(0, 0, -10000, 10000);
        sample_at(0, 0, 10000);
        sample_at(0, 0, -10000);
        sample_at(0, 36, 9000);
        sample_at(0, 72, 8400);
        sample_at(0, 0, 8000);
        sample_at(0, 0, 7800);
        sample_at(0, 0, VAL_W'(VAL_MIN));
        sample_at(0, 0, VAL_W'(VAL_MAX));
        // equal bounds, then a write past the last period that must not land
        write_entry(63, 35, VAL_W'(VAL_MAX), VAL_W'(VAL_MAX));
        sample_at(63, 35, 0);
        write_entry(63, 63, VAL_W'(VAL_MIN), VAL_W'(VAL_MAX));
        sample_at(63, 35, VAL_W'(VAL_MIN));
        // reversed bounds
        write_entry(5, 0, 9000, -9000);
        sample_at(5, 0, 0);
        sample_at(5, 0, 9000);
        sample_at(5, 0, -9000);
        // last band of the series wraps onto period 27
        write_entry(1, 27, VAL_W'(VAL_MIN), VAL_W'(VAL_MAX));
        sample_at(1, 4095, 0);
        send_item(CMD_SAMPLE, item_data(63, 1'b0, 63, -1, -1, 4095, -1));
        write_entry(2, 1, VAL_W'(VAL_MAX), VAL_W'(VAL_MIN));
        sample_at(2, 1, VAL_W'(VAL_MIN));
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                set_reg(CFG_START_DEKAD, CFG_W'(start_set[ph]));
                set_reg(CFG_PERIOD_COUNT, CFG_W'(pc_set[ph]));
            end
            calm = (ph % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
            end
            drain();
        end
        calm = 1'b0;

        $display("Covered %0d table writes and %0d samples over %0d register settings,",
                 sb.n_writes, sb.n_samples, NUM_PHASES);
        $display("with %0d results checked, %0d of them on equal bounds.",
                 sb.n_checked, sb.n_degen);
        if (sb.errors == 0 && sb.pct_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
